// File: design/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// Standalone package; no dependencies.
package pps_pkg;

  localparam int TIME_W = 24;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // One table row as held in the process memory.
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] remaining;
  } pps_entry_t;

  // Input payload; last field in the lowest bits.
  typedef struct packed {
    logic [7:0]  priority_level;
    logic [15:0] burst_time;
    logic [15:0] arrival_time;
    logic [3:0]  entry_index;
  } pps_in_t;

  // Result payload; last field in the lowest bits.
  typedef struct packed {
    logic [TIME_W-1:0] current_time;
    logic              all_done;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] completion_time;
    logic              finished;
    logic [3:0]        ran_index;
    logic              ran_valid;
  } pps_result_t;

endpackage

// File: design/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler, top level: process memory, scan engine, result register.
// Depends on pps_pkg.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------------------
//  in_     | slave     | in_tvalid/tready   | tuser: operation; tdata: index,arr,burst,prio
//  out_    | master    | out_tvalid/tready  | tdata: result fields, see port comment
//  cfg_    | slave     | cfg_valid/ready    | cfg_data: process_count
//
// Sequence: a transaction (load or tick) is accepted only when idle; it then passes the scan,
//   calc and emit states, and the next one is taken once its result is registered. The
//   process memory, with one write port and a registered read, is scanned one entry per cycle.
// Reset: rst_n, synchronous. Pending bits of all rows clear at once; no clearing pass.
// Stalls: a result waits in the output register; the next input transaction is taken
//   meanwhile and the block holds before emitting only if that register is still full.
module preemptive_priority_scheduler_top
  import pps_pkg::*;
#(
  parameter int MAX_PROCESSES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // input transaction
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,   // [0] operation
  input  logic [47:0]  in_tdata,   // [3:0] entry_index, [19:4] arrival_time,
                                   // [35:20] burst_time, [43:36] priority_level
  // result transaction
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [0] ran_valid, [4:1] ran_index, [5] finished,
                                   // [29:6] completion_time, [53:30] turnaround,
                                   // [77:54] waiting, [78] all_done, [102:79] current_time
  // configuration
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data     // process_count
);

  localparam int IDX_W = $clog2(MAX_PROCESSES);
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  pps_in_t in_item;
  assign in_item = pps_in_t'(in_tdata[$bits(pps_in_t)-1:0]);

  // ---------------------------------------------------------------------------
  // Configuration: clamp count to table size on write.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] cnt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (32'(cfg_data) > 32'(MAX_PROCESSES))
        cnt_r <= CNT_W'(MAX_PROCESSES);
      else
        cnt_r <= CNT_W'(cfg_data);
    end
  end

  // ---------------------------------------------------------------------------
  // Control and scan state
  // ---------------------------------------------------------------------------
  logic [1:0]        state_r;
  logic              op_r;
  logic [CNT_W-1:0]  scan_r;
  logic              rd_vld_r;
  logic [1:0]        pcnt_r;      // pending rows seen, saturates at 2
  logic              have_r;
  logic [IDX_W-1:0]  best_idx_r;
  pps_entry_t        best_r;
  logic [TIME_W-1:0] time_r;
  logic [TIME_W-1:0] ct_r;        // time after this tick, saturated
  logic [TIME_W-1:0] tat_r;
  logic              fin_r;
  logic              out_valid_r;
  pps_result_t       out_data_r;

  // Process memory and its pending bits (pending == remaining != 0).
  pps_entry_t             mem [MAX_PROCESSES];
  pps_entry_t             rd_entry_r;
  logic [MAX_PROCESSES-1:0] pend_r;
  logic                   rd_pend_r;

  logic             in_acc;
  logic             load_ok;
  logic [IDX_W-1:0] load_addr;
  logic             scan_more;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  pps_entry_t       mem_wd;
  logic             calc_we;
  logic             out_free;
  logic             better;
  pps_entry_t       load_entry;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign load_ok   = ({28'd0, in_item.entry_index} < 32'(MAX_PROCESSES));
  assign load_addr = IDX_W'({28'd0, in_item.entry_index});
  assign scan_more = (scan_r < cnt_r);
  assign rd_addr   = scan_more ? scan_r[IDX_W-1:0] : '0;
  assign calc_we   = (state_r == ST_CALC) && (op_r == OP_TICK) && have_r;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    load_entry.arrival   = in_item.arrival_time;
    load_entry.burst     = in_item.burst_time;
    load_entry.prio      = in_item.priority_level;
    load_entry.remaining = in_item.burst_time;
  end

  // One write port: either a load at accept or the tick write-back.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = load_addr;
    mem_wd = load_entry;
    if (in_acc && (in_tuser == OP_LOAD) && load_ok) begin
      mem_we = 1'b1;
    end else if (calc_we) begin
      mem_we           = 1'b1;
      mem_wa           = best_idx_r;
      mem_wd           = best_r;
      mem_wd.remaining = best_r.remaining - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we)
      mem[mem_wa] <= mem_wd;
    rd_entry_r <= mem[rd_addr];
    rd_pend_r  <= pend_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (mem_we) begin
      pend_r[mem_wa] <= (mem_wd.remaining != 16'd0);
    end
  end

  // Candidate beats current best: lower priority number, then earlier arrival.
  always_comb begin
    better = !have_r
          || (rd_entry_r.prio < best_r.prio)
          || ((rd_entry_r.prio == best_r.prio) && (rd_entry_r.arrival < best_r.arrival));
  end

  // ---------------------------------------------------------------------------
  // Result valid: set when the emit step loads the register, cleared on handoff.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_LOAD;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      pcnt_r      <= '0;
      have_r      <= 1'b0;
      time_r      <= '0;
      fin_r       <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            op_r     <= in_tuser;
            scan_r   <= '0;
            rd_vld_r <= 1'b0;
            pcnt_r   <= '0;
            have_r   <= 1'b0;
            fin_r    <= 1'b0;
            ct_r     <= (time_r == TIME_MAX) ? TIME_MAX : time_r + TIME_W'(1);
            state_r  <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          rd_vld_r <= scan_more;
          if (scan_more)
            scan_r <= scan_r + CNT_W'(1);
          if (rd_vld_r && rd_pend_r) begin
            if (pcnt_r != 2'd2)
              pcnt_r <= pcnt_r + 2'd1;
            if ((op_r == OP_TICK) && ({8'd0, rd_entry_r.arrival} <= time_r) && better) begin
              have_r     <= 1'b1;
              best_idx_r <= IDX_W'(scan_r - CNT_W'(1));
              best_r     <= rd_entry_r;
            end
          end
          if (!scan_more && !rd_vld_r)
            state_r <= ST_CALC;
        end

        ST_CALC: begin
          // remaining write-back happens through the memory port above
          fin_r <= calc_we && (best_r.remaining == 16'd1);
          tat_r <= ct_r - {8'd0, best_r.arrival};
          if (op_r == OP_TICK)
            time_r <= ct_r;
          state_r <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            out_data_r.ran_valid       <= have_r;
            out_data_r.ran_index       <= have_r ? 4'(best_idx_r) : 4'd0;
            out_data_r.finished        <= fin_r;
            out_data_r.completion_time <= fin_r ? time_r : '0;
            out_data_r.turnaround      <= fin_r ? tat_r : '0;
            if (fin_r && (tat_r >= {8'd0, best_r.burst}))
              out_data_r.waiting <= tat_r - {8'd0, best_r.burst};
            else
              out_data_r.waiting <= '0;
            out_data_r.all_done        <= (pcnt_r == 2'd0) || ((pcnt_r == 2'd1) && fin_r);
            out_data_r.current_time    <= time_r;
            state_r                    <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

endmodule
